[sv/mst_pkg.sv]
// Shared types and codes for the minimum spanning tree engine.
package mst_pkg;

	localparam logic [0:0] REQ_ADD = 1'b0;
	localparam logic [0:0] REQ_RUN = 1'b1;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_EDGE = 2'd1;
	localparam logic [1:0] KIND_SUM  = 2'd2;

	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [0:0] CFG_VCOUNT   = 1'b0;
	localparam logic [0:0] CFG_WEIGHTED = 1'b1;

	localparam int COST_BITS = 20;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_WAIT,
		S_PICK,
		S_SUM
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic add_eval;    // check and store the captured edge, emit ack
		logic run_init;    // start a run: tree = {0}, cost = 0
		logic scan_clear;  // clear best candidate before a scan
		logic scan_step;   // examine the current (t, v) pair
		logic scan_flush;  // wait state while the last weight read folds into the best
		logic pick;        // join best vertex, emit tree edge
		logic summary;     // emit run summary
	} mst_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scan_done;   // pair counter at its last pair
		logic found;       // a crossing edge was found
		logic all_in;      // every live vertex is in the tree
	} mst_stat_t;

endpackage

[sv/mst_ctrl.sv]
// Controller state machine for edge loading and the Prim run.
module mst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	input  mst_pkg::mst_stat_t  stat,
	output logic                busy,
	output mst_pkg::mst_cmd_t   cmd
);

	mst_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mst_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			mst_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == mst_pkg::REQ_RUN) begin
						cmd.run_init = 1'b1;
						cmd.scan_clear = 1'b1;
						state_d = mst_pkg::S_SCAN;
					end else begin
						state_d = mst_pkg::S_ADD;
					end
				end
			end
			mst_pkg::S_ADD: begin
				cmd.add_eval = 1'b1;
				state_d = mst_pkg::S_IDLE;
			end
			mst_pkg::S_SCAN: begin
				if (stat.all_in) begin
					state_d = mst_pkg::S_SUM;
				end else begin
					cmd.scan_step = 1'b1;
					if (stat.scan_done) state_d = mst_pkg::S_WAIT;
				end
			end
			mst_pkg::S_WAIT: begin
				cmd.scan_flush = 1'b1;
				state_d = mst_pkg::S_PICK;
			end
			mst_pkg::S_PICK: begin
				if (stat.found) begin
					cmd.pick = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d = mst_pkg::S_SCAN;
				end else begin
					state_d = mst_pkg::S_SUM;
				end
			end
			mst_pkg::S_SUM: begin
				cmd.summary = 1'b1;
				state_d = mst_pkg::S_IDLE;
			end
			default: state_d = mst_pkg::S_IDLE;
		endcase
	end

	// Checks
	a_sum_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mst_pkg::S_SUM |=> state_q == mst_pkg::S_IDLE)
		else $error("summary did not return to idle");
	a_add_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mst_pkg::S_ADD |=> !busy)
		else $error("add took more than one cycle");
	a_onecmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_eval, cmd.pick, cmd.summary, cmd.scan_flush}))
		else $error("conflicting commands");

endmodule

[sv/mst_dp.sv]
// Datapath: adjacency rows, weight memory, pair scanner and result register.
module mst_dp #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [5:0]                end_a,
	input  logic [5:0]                end_b,
	input  logic signed [15:0]        edge_weight,
	input  logic [4:0]                vcount_q,
	input  logic                      weighted_q,
	input  mst_pkg::mst_cmd_t         cmd,
	output mst_pkg::mst_stat_t        stat,
	output logic                      result_valid,
	output logic [1:0]                result_kind,
	output logic [1:0]                status,
	output logic [3:0]                tree_vertex,
	output logic [3:0]                new_vertex,
	output logic signed [15:0]        tree_edge_weight,
	output logic signed [19:0]        total_cost,
	output logic                      all_reached,
	output logic                      last
);

	localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int PB = 2 * VB;
	localparam int NV = MAX_VERTICES;
	localparam int CB = mst_pkg::COST_BITS;

	logic [NV-1:0] adj_q [NV];
	logic [NV-1:0] adj_valid_q;
	logic [WEIGHT_BITS-1:0] wmem [NV*NV];
	logic [NV-1:0] tree_q;
	logic [CB-1:0] cost_q;

	logic [5:0] a_q, b_q;
	logic [15:0] w_in_q;

	// Effective vertex count: zero acts as one, saturated at the maximum
	logic [6:0] n_eff;
	always_comb begin
		n_eff = {2'b00, vcount_q};
		if (n_eff == 7'd0) n_eff = 7'd1;
		if (n_eff > 7'(NV)) n_eff = 7'(NV);
	end

	logic [NV-1:0] live;
	always_comb begin
		for (int i = 0; i < NV; i++) live[i] = (7'(i) < n_eff);
	end

	// Capture request word
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			a_q <= end_a;
			b_q <= end_b;
			w_in_q <= edge_weight;
		end
	end

	logic [NV-1:0] adj_rd [NV];
	always_comb begin
		for (int i = 0; i < NV; i++) adj_rd[i] = adj_valid_q[i] ? adj_q[i] : '0;
	end

	// Add-edge checks
	logic [VB-1:0] ai, bi;
	logic a_ok, b_ok, dup;
	assign a_ok = ({1'b0, a_q} < n_eff);
	assign b_ok = ({1'b0, b_q} < n_eff);
	assign ai = a_q[VB-1:0];
	assign bi = b_q[VB-1:0];
	assign dup = (a_q == b_q) || adj_rd[ai][bi];
	logic do_add;
	assign do_add = cmd.add_eval && a_ok && b_ok && !dup;

	logic [VB-1:0] lo_i, hi_i;
	assign lo_i = (ai < bi) ? ai : bi;
	assign hi_i = (ai < bi) ? bi : ai;

	logic [WEIGHT_BITS-1:0] w_store;
	assign w_store = weighted_q
		? WEIGHT_BITS'($signed(w_in_q)) : '0;

	// Adjacency rows: row valid bits give the empty reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) adj_valid_q <= '0;
		else if (do_add) adj_valid_q <= adj_valid_q | (NV'(1) << ai) | (NV'(1) << bi);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NV; i++) begin
			if (do_add && (VB'(i) == ai || VB'(i) == bi))
				adj_q[i] <= adj_rd[i] | ((NV'(1) << bi) & {NV{VB'(i) == ai}})
					| ((NV'(1) << ai) & {NV{VB'(i) == bi}});
		end
	end

	// Pair scanner: v is the outer index, t the inner one
	logic [VB-1:0] v_q, t_q;
	logic [PB-1:0] last_pair;
	assign last_pair = {VB'(n_eff - 7'd1), VB'(n_eff - 7'd1)};
	assign stat.scan_done = ({v_q, t_q} == last_pair);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			t_q <= '0;
		end else if (cmd.scan_clear) begin
			v_q <= '0;
			t_q <= '0;
		end else if (cmd.scan_step && !stat.scan_done) begin
			if (7'(t_q) == n_eff - 7'd1) begin
				t_q <= '0;
				v_q <= v_q + VB'(1);
			end else begin
				t_q <= t_q + VB'(1);
			end
		end
	end

	// Stage 1: candidate test and weight memory read
	logic cand;
	assign cand = cmd.scan_step && !tree_q[v_q] && tree_q[t_q] && adj_rd[t_q][v_q];
	logic [VB-1:0] plo, phi;
	assign plo = (t_q < v_q) ? t_q : v_q;
	assign phi = (t_q < v_q) ? v_q : t_q;

	logic cand_s1;
	logic [VB-1:0] t_s1, v_s1;
	logic [WEIGHT_BITS-1:0] w_s1;

	always_ff @(posedge clk) begin
		if (do_add) wmem[{lo_i, hi_i}] <= w_store;
		w_s1 <= wmem[{plo, phi}];
		t_s1 <= t_q;
		v_s1 <= v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cand_s1 <= 1'b0;
		else cand_s1 <= cand;
	end

	// Stage 2: best-candidate compare, first strict minimum wins
	logic found_q;
	logic signed [WEIGHT_BITS-1:0] bw_q;
	logic [VB-1:0] bt_q, bn_q;
	logic signed [WEIGHT_BITS-1:0] w_eff;
	assign w_eff = weighted_q ? $signed(w_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) found_q <= 1'b0;
		else if (cmd.scan_clear) found_q <= 1'b0;
		else if (cand_s1 && (!found_q || w_eff < bw_q)) found_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cand_s1 && (!found_q || w_eff < bw_q)) begin
			bw_q <= w_eff;
			bt_q <= t_s1;
			bn_q <= v_s1;
		end
	end

	assign stat.found = found_q;
	assign stat.all_in = ((tree_q & live) == live);

	// Tree mask and running cost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_q <= '0;
			cost_q <= '0;
		end else if (cmd.run_init) begin
			tree_q <= NV'(1);
			cost_q <= '0;
		end else if (cmd.pick) begin
			tree_q[bn_q] <= 1'b1;
			cost_q <= cost_q + CB'(bw_q);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= cmd.add_eval || cmd.pick || cmd.summary;
	end

	logic [1:0] kind_d, status_d;
	logic [3:0] tv_d, nv_d;
	logic signed [15:0] tw_d;
	logic signed [19:0] cost_d;
	logic all_d, last_d;

	always_comb begin
		kind_d = mst_pkg::KIND_ACK;
		status_d = mst_pkg::ST_ADDED;
		tv_d = '0;
		nv_d = '0;
		tw_d = '0;
		cost_d = '0;
		all_d = 1'b0;
		last_d = 1'b0;
		if (cmd.add_eval) begin
			last_d = 1'b1;
			if (!a_ok || !b_ok) status_d = mst_pkg::ST_RANGE;
			else if (dup) status_d = mst_pkg::ST_DUP;
		end else if (cmd.pick) begin
			kind_d = mst_pkg::KIND_EDGE;
			tv_d = 4'(bt_q);
			nv_d = 4'(bn_q);
			tw_d = 16'(bw_q);
		end else if (cmd.summary) begin
			kind_d = mst_pkg::KIND_SUM;
			cost_d = $signed(cost_q);
			all_d = stat.all_in;
			last_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		result_kind <= kind_d;
		status <= status_d;
		tree_vertex <= tv_d;
		new_vertex <= nv_d;
		tree_edge_weight <= tw_d;
		total_cost <= cost_d;
		all_reached <= all_d;
		last <= last_d;
	end

	// Checks
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_init |=> tree_q == NV'(1))
		else $error("run did not start from vertex 0");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |=> $countones(tree_q) == $countones($past(tree_q)) + 1)
		else $error("pick did not add exactly one vertex");
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == mst_pkg::KIND_SUM |-> last)
		else $error("summary without last");

endmodule

[sv/minimum_spanning_tree_engine.sv]
// Top level of the minimum spanning tree engine.
//
// channel   direction  handshake             fields
// request   in         start / busy          req_type end_a end_b edge_weight
// config    in         cfg_valid / cfg_ready cfg_index cfg_data
// result    out        result_valid strobe   result_kind .. last
//
// An add-edge word keeps busy high for one cycle; its acknowledge is registered
// onto the result ports from the S_ADD state.
// A run keeps busy high until its summary is issued, whether it reaches every
// vertex or the graph is split; each result appears in the cycle after its pick.
// The vertex pairs are scanned serially.
// Reset clears adjacency, tree mask, cost and the control and valid registers at once.
// The result strobe lasts one cycle; the receiver cannot stall it.
module minimum_spanning_tree_engine #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [5:0]         end_a,
	input  logic [5:0]         end_b,
	input  logic signed [15:0] edge_weight,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	output logic               result_valid,
	output logic [1:0]         result_kind,
	output logic [1:0]         status,
	output logic [3:0]         tree_vertex,
	output logic [3:0]         new_vertex,
	output logic signed [15:0] tree_edge_weight,
	output logic signed [19:0] total_cost,
	output logic               all_reached,
	output logic               last
);

	mst_pkg::mst_cmd_t  cmd;
	mst_pkg::mst_stat_t stat;
	logic [4:0] vcount_q;
	logic weighted_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 5'd16;
			weighted_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == mst_pkg::CFG_VCOUNT) vcount_q <= cfg_data;
			else weighted_q <= cfg_data[0];
		end
	end

	mst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.stat(stat), .busy(busy), .cmd(cmd)
	);

	mst_dp #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.end_a(end_a), .end_b(end_b), .edge_weight(edge_weight),
		.vcount_q(vcount_q), .weighted_q(weighted_q), .cmd(cmd), .stat(stat),
		.result_valid(result_valid), .result_kind(result_kind), .status(status),
		.tree_vertex(tree_vertex), .new_vertex(new_vertex),
		.tree_edge_weight(tree_edge_weight), .total_cost(total_cost),
		.all_reached(all_reached), .last(last)
	);

endmodule
